// ----- src/rfa_pkg.sv -----
// Shared types and constants for the page frame allocator.
`default_nettype none

package rfa_pkg;

  localparam int CFG_W     = 13;
  localparam int FRAME_W   = 12;
  localparam int REF_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int FUNC_W    = 2;
  localparam int FREE_W    = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SHARE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL = 1'd1;

  localparam logic [CFG_W-1:0] FIRST_FRAME_RST = 13'd256;
  localparam logic [CFG_W-1:0] FRAME_TOTAL_RST = 13'd4096;

  typedef struct packed {
    logic [CFG_W-1:0] first_frame;
    logic [CFG_W-1:0] frame_total;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/rfa_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/rfa_ctrl.sv -----
// Sequencer: clearing pass, free recount, allocate scan and count read-modify-write.
`default_nettype none

module rfa_ctrl
  import rfa_pkg::*;
#(
  parameter int FRAME_COUNT = 4096,
  parameter int REF_LIMIT   = 254
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                cfg_wr,
  input  wire logic                start,
  input  wire logic [FUNC_W-1:0]   func,
  input  wire logic [FRAME_W-1:0]  frame,
  output logic                     busy,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [FRAME_W-1:0]       frame_out,
  output logic [REF_W-1:0]         ref_after,
  output logic [FREE_W-1:0]        free_count
);

  localparam int AW = $clog2(FRAME_COUNT);
  localparam int IW = ((AW > CFG_W) ? AW : CFG_W) + 1;
  localparam logic [IW-1:0]    FC_X  = IW'(FRAME_COUNT);
  localparam logic [REF_W-1:0] LIMIT = REF_W'(REF_LIMIT);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_COUNT    = 3'd2;
  localparam logic [2:0] S_DISPATCH = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_RMW      = 3'd5;

  logic [2:0]         state;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      paddr;
  logic               pend;
  logic [IW-1:0]      acc;
  logic [IW-1:0]      free;
  logic               dirty;
  logic [FUNC_W-1:0]  item_func;
  logic [FRAME_W-1:0] item_frame;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [REF_W-1:0]   ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [REF_W-1:0]   ram_rdata;

  logic [IW-1:0]       first_x;
  logic [IW-1:0]       total_x;
  logic [IW-1:0]       top_x;
  logic [IW-1:0]       item_frame_x;
  logic                hit;
  logic                more;
  logic                in_range;
  logic [IW-1:0]       acc_next;
  logic [IW-1:0]       free_next;
  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [IW-1:0]       emit_frame;
  logic [REF_W-1:0]    emit_ref;

  rfa_ram #(
    .WIDTH(REF_W),
    .DEPTH(FRAME_COUNT)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign first_x      = IW'(cfg.first_frame);
  assign total_x      = IW'(cfg.frame_total);
  assign top_x        = (total_x > FC_X) ? FC_X : total_x;
  assign item_frame_x = IW'(item_frame);
  assign hit          = pend && (ram_rdata == '0);
  assign more         = idx < top_x;
  assign in_range     = (item_frame_x >= first_x) && (item_frame_x < top_x);
  assign acc_next     = acc + IW'(hit);
  assign busy         = (state != S_IDLE);

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = idx[AW-1:0];
    ram_wdata   = '0;
    ram_raddr   = idx[AW-1:0];
    free_next   = free;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_frame  = item_frame_x;
    emit_ref    = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_COUNT: begin
        if (!more) begin
          free_next = acc_next;
        end
      end
      S_DISPATCH: begin
        ram_raddr = item_frame_x[AW-1:0];
        if (item_func != FN_ALLOC &&
            !((item_func == FN_RELEASE || item_func == FN_SHARE) && in_range)) begin
          emit        = 1'b1;
          emit_status = ST_RANGE;
        end
      end
      S_SCAN: begin
        if (hit) begin
          ram_we     = 1'b1;
          ram_waddr  = paddr[AW-1:0];
          ram_wdata  = REF_W'(1);
          free_next  = free - IW'(1);
          emit       = 1'b1;
          emit_frame = paddr;
          emit_ref   = REF_W'(1);
        end else if (!more) begin
          emit        = 1'b1;
          emit_status = ST_OOM;
          emit_frame  = '0;
        end
      end
      S_RMW: begin
        emit      = 1'b1;
        ram_waddr = item_frame_x[AW-1:0];
        if (ram_rdata == '0) begin
          emit_status = ST_FREE;
        end else if (item_func == FN_RELEASE) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata - REF_W'(1);
          emit_ref  = ram_rdata - REF_W'(1);
          if (ram_rdata == REF_W'(1)) begin
            free_next = free + IW'(1);
          end
        end else if (ram_rdata >= LIMIT) begin
          emit_status = ST_LIMIT;
          emit_ref    = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata + REF_W'(1);
          emit_ref  = ram_rdata + REF_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      pend  <= 1'b0;
      dirty <= 1'b1;
      free  <= '0;
      done  <= 1'b0;
    end else begin
      done <= emit;
      free <= free_next;
      unique case (state)
        S_CLEAR: begin
          idx <= idx + IW'(1);
          if (idx == FC_X - IW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            item_func  <= func;
            item_frame <= frame;
            idx        <= first_x;
            pend       <= 1'b0;
            acc        <= '0;
            state      <= dirty ? S_COUNT : S_DISPATCH;
          end
        end
        S_COUNT: begin
          if (more) begin
            idx   <= idx + IW'(1);
            pend  <= 1'b1;
            acc   <= acc_next;
          end else begin
            idx   <= first_x;
            pend  <= 1'b0;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (item_func == FN_ALLOC) begin
            state <= S_SCAN;
          end else if (emit) begin
            state <= S_IDLE;
          end else begin
            state <= S_RMW;
          end
        end
        S_SCAN: begin
          if (emit) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + IW'(1);
            pend  <= 1'b1;
            paddr <= idx;
          end
        end
        S_RMW: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_wr) begin
        dirty <= 1'b1;
      end else if (state == S_COUNT && !more) begin
        dirty <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status     <= emit_status;
      frame_out  <= emit_frame[FRAME_W-1:0];
      ref_after  <= emit_ref;
      free_count <= free_next[FREE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- src/refcounted_page_frame_allocator_unit.sv -----
// Top level: configuration registers, sequencer and checks.
//
// A command is taken when start is high and busy is low; its single result
// word appears one cycle with done high and must be captured then. After
// reset the count store is swept to zero, one frame a cycle, with busy
// high. The first command after reset or after any register write first
// recounts free frames over the allocatable range, one frame a cycle.
// Release and share then pass through dispatch and a read-modify-write of
// the count; rejected commands return to idle from dispatch. Allocate
// reads the count store one frame a cycle from first_frame upward until
// it finds a frame with a zero count or reaches the end of the range.
`default_nettype none

module refcounted_page_frame_allocator_unit
  import rfa_pkg::*;
#(
  parameter int FRAME_COUNT = 4096,
  parameter int REF_LIMIT   = 254
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 start,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [FRAME_W-1:0]   frame,
  output logic                      busy,
  output logic                      done,
  output logic [STATUS_W-1:0]       status,
  output logic [FRAME_W-1:0]        frame_out,
  output logic [REF_W-1:0]          ref_after,
  output logic [FREE_W-1:0]         free_count
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_frame <= FIRST_FRAME_RST;
      cfg.frame_total <= FRAME_TOTAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_FRAME: cfg.first_frame <= cfg_wdata;
        CFG_FRAME_TOTAL: cfg.frame_total <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rfa_ctrl #(
    .FRAME_COUNT(FRAME_COUNT),
    .REF_LIMIT  (REF_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_wr    (cfg_we),
    .start     (start),
    .func      (func),
    .frame     (frame),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .frame_out (frame_out),
    .ref_after (ref_after),
    .free_count(free_count)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a command in progress");

  a_oom_word: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OOM |-> frame_out == '0 && ref_after == '0)
    else $error("out of memory word carries a frame");

  a_limit_word: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_LIMIT |-> ref_after >= REF_W'(REF_LIMIT))
    else $error("limit status below the count limit");
`endif

endmodule

`default_nettype wire
